/* rtl/pool22_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the 2x2 average/max pooling block
// no dependencies; every other file but pool22_ram uses this package
package pool22_pkg;

  localparam int MAX_OUT_COLS = 256;
  localparam int MAX_OUT_ROWS = 256;
  localparam int SAMPLE_BITS  = 16;

  // width of the dimension registers
  localparam int DIM_W   = 9;
  // column buffer address and row counter widths
  localparam int COL_AW  = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;
  localparam int ROW_W   = (MAX_OUT_ROWS > 1) ? $clog2(MAX_OUT_ROWS) : 1;
  // pair result (sum or max of two) and final Q8.10 result widths
  localparam int PAIR_W  = SAMPLE_BITS + 1;
  localparam int OUT_W   = SAMPLE_BITS + 2;

  localparam int NUM_REGS = 3;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [DIM_W-1:0] OUT_ROWS_RESET = DIM_W'(14);
  localparam logic [DIM_W-1:0] OUT_COLS_RESET = DIM_W'(14);

  typedef enum logic [1:0] {
    REG_OUT_ROWS  = 2'd0,
    REG_OUT_COLS  = 2'd1,
    REG_POOL_MODE = 2'd2
  } reg_idx_t;

  typedef enum logic {
    MODE_AVG = 1'b0,
    MODE_MAX = 1'b1
  } pool_mode_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    pool_mode_t       mode;
    logic             restart;
  } cfg_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    done;
  } result_t;

endpackage

/* rtl/pool22_sample_if.sv */
`timescale 1ns / 1ps
// valid/ready stream channels for input samples and pooled results
// depends on pool22_pkg for field widths
interface pool22_sample_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [pool22_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
  modport mon    (input valid, input sample, input ready);
endinterface

interface pool22_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [pool22_pkg::OUT_W-1:0] pooled_value;
  logic                                map_done;

  modport source (output valid, output pooled_value, output map_done, input ready);
  modport sink   (input valid, input pooled_value, input map_done, output ready);
  modport mon    (input valid, input pooled_value, input map_done, input ready);
endinterface

/* rtl/pool22_cfg.sv */
`timescale 1ns / 1ps
// apb register file: map dimensions and pooling mode
// depends on pool22_pkg
module pool22_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pool22_pkg::PADDR_W-1:0]     paddr,
  input  logic [pool22_pkg::PDATA_W-1:0]     pwdata,
  output logic [pool22_pkg::PDATA_W-1:0]     prdata,
  output logic                               pready,
  output pool22_pkg::cfg_t                   cfg
);
  import pool22_pkg::*;

  logic [DIM_W-1:0] out_rows;
  logic [DIM_W-1:0] out_cols;
  pool_mode_t       pool_mode;
  logic             restart;
  logic             wr_en;
  reg_idx_t         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

  // the map restarts at the same edge that writes the register
  assign restart = wr_en && (idx inside {REG_OUT_ROWS, REG_OUT_COLS, REG_POOL_MODE});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_rows  <= OUT_ROWS_RESET;
      out_cols  <= OUT_COLS_RESET;
      pool_mode <= MODE_AVG;
    end else begin
      if (wr_en) begin
        case (idx)
          REG_OUT_ROWS: begin
            out_rows <= pwdata[DIM_W-1:0];
          end
          REG_OUT_COLS: begin
            out_cols <= pwdata[DIM_W-1:0];
          end
          REG_POOL_MODE: begin
            pool_mode <= pool_mode_t'(pwdata[0]);
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_OUT_ROWS:  prdata = PDATA_W'(out_rows);
      REG_OUT_COLS:  prdata = PDATA_W'(out_cols);
      REG_POOL_MODE: prdata = PDATA_W'(pool_mode);
      default:       prdata = '0;
    endcase
  end

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (out_rows == '0)
      cfg.rows = DIM_W'(1);
    else if (int'(out_rows) > MAX_OUT_ROWS)
      cfg.rows = DIM_W'(MAX_OUT_ROWS);
    else
      cfg.rows = out_rows;
    if (out_cols == '0)
      cfg.cols = DIM_W'(1);
    else if (int'(out_cols) > MAX_OUT_COLS)
      cfg.cols = DIM_W'(MAX_OUT_COLS);
    else
      cfg.cols = out_cols;
    cfg.mode    = pool_mode;
    cfg.restart = restart;
  end

endmodule

/* rtl/pool22_ram.sv */
`timescale 1ns / 1ps
// single-port-write, single-port-read ram with registered read data
// generic; no package dependency
module pool22_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en)
      mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en)
      rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/pool22_core.sv */
`timescale 1ns / 1ps
// window position tracking, pair combine and column-buffer read/modify/write
// depends on pool22_pkg; drives the column ram and the output queue
module pool22_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  pool22_pkg::cfg_t                       cfg,
  input  logic                                   in_valid,
  input  logic signed [pool22_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                   in_ready,
  input  logic                                   q_full,
  output logic                                   push,
  output pool22_pkg::result_t                    push_data,
  output logic                                   ram_wr_en,
  output logic [pool22_pkg::COL_AW-1:0]          ram_wr_addr,
  output logic [pool22_pkg::PAIR_W-1:0]          ram_wr_data,
  output logic                                   ram_rd_en,
  output logic [pool22_pkg::COL_AW-1:0]          ram_rd_addr,
  input  logic [pool22_pkg::PAIR_W-1:0]          ram_rd_data
);
  import pool22_pkg::*;

  logic                       col_phase;
  logic                       row_phase;
  logic [COL_AW-1:0]          col_pos;
  logic [ROW_W-1:0]           row_pos;
  logic signed [SAMPLE_BITS-1:0] held_left;

  logic                       fire;
  logic                       last_col;
  logic                       last_row;
  logic signed [PAIR_W-1:0]   left_x;
  logic signed [PAIR_W-1:0]   right_x;
  logic signed [PAIR_W-1:0]   pair;
  logic signed [PAIR_W-1:0]   top;
  logic signed [OUT_W-1:0]    window;

  // only a bottom-right sample needs room in the output queue
  assign in_ready = !(q_full && col_phase && row_phase);
  assign fire     = in_valid && in_ready;

  assign last_col = (32'(col_pos) + 32'd1) >= 32'(cfg.cols);
  assign last_row = (32'(row_pos) + 32'd1) >= 32'(cfg.rows);

  assign left_x  = PAIR_W'(held_left);
  assign right_x = PAIR_W'(in_sample);
  assign top     = signed'(ram_rd_data);

  always_comb begin
    if (cfg.mode == MODE_MAX)
      pair = (left_x > right_x) ? left_x : right_x;
    else
      pair = left_x + right_x;
  end

  always_comb begin
    if (cfg.mode == MODE_MAX) begin
      if (top > pair)
        window = {top[PAIR_W-2:0], 2'b00};
      else
        window = {pair[PAIR_W-2:0], 2'b00};
    end else begin
      window = OUT_W'(top) + OUT_W'(pair);
    end
  end

  // top-row partial is fetched on the bottom-left sample, ready for the next
  assign ram_rd_en   = fire && !col_phase && row_phase;
  assign ram_rd_addr = col_pos;
  assign ram_wr_en   = fire && col_phase && !row_phase;
  assign ram_wr_addr = col_pos;
  assign ram_wr_data = pair;

  assign push            = fire && col_phase && row_phase;
  assign push_data.value = window;
  assign push_data.done  = last_row && last_col;

  always_ff @(posedge clk) begin
    if (fire && !col_phase)
      held_left <= in_sample;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      col_phase <= 1'b0;
      row_phase <= 1'b0;
      col_pos   <= '0;
      row_pos   <= '0;
    end else if (fire) begin
      col_phase <= !col_phase;
      if (col_phase) begin
        if (last_col) begin
          col_pos   <= '0;
          row_phase <= !row_phase;
          if (row_phase)
            row_pos <= last_row ? '0 : row_pos + ROW_W'(1);
        end else begin
          col_pos <= col_pos + COL_AW'(1);
        end
      end
    end
  end

endmodule

/* rtl/pool22_outq.sv */
`timescale 1ns / 1ps
// two-entry result queue between the datapath and the output channel
// depends on pool22_pkg
module pool22_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pool22_pkg::result_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_ready,
  output pool22_pkg::result_t out_data
);
  import pool22_pkg::*;

  result_t     entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push)
      entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push)
        wr_ptr <= !wr_ptr;
      if (pop)
        rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/pool_2x2_average_max.sv */
`timescale 1ns / 1ps
// 2x2 stride-2 pooling, average (exact sum of four) or maximum (times four)
// depends on pool22_pkg, the stream interfaces and pool22_cfg/core/ram/outq
//
// usage:
//  - samples: signed Q8.8 feature-map samples in raster order, maps back to
//    back, each map 2*out_rows by 2*out_cols samples.
//  - results: one signed Q8.10 value per 2x2 window, map_done set on the last
//    window of a map.
//  - apb: out_rows (0x0), out_cols (0x4), pool_mode (0x8). a write to any of them
//    restarts the map; write only while no transaction is in flight.
//  - one sample per cycle sustained while the output queue is not full. a window
//    result is registered into the output queue at the edge that takes its
//    bottom-right sample and shows on results once earlier results are taken.
//  - the top-row pair of each window is kept in a 256-entry column ram; its
//    read is issued on the bottom-left sample, ahead of use on the bottom-right.
//  - receiver stall: a two-entry queue holds results; when it is full only
//    the bottom-right sample of a window is held off, others keep flowing.
//  - reset clears positions, the queue and the registers (14 x 14, average);
//    the column ram is not cleared and needs no clearing.
module pool_2x2_average_max (
  input  logic                           clk,
  input  logic                           rst,
  pool22_sample_if.sink                  samples,
  pool22_result_if.source                results,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pool22_pkg::PADDR_W-1:0] paddr,
  input  logic [pool22_pkg::PDATA_W-1:0] pwdata,
  output logic [pool22_pkg::PDATA_W-1:0] prdata,
  output logic                           pready
);
  import pool22_pkg::*;

  cfg_t              cfg;
  logic              q_full;
  logic              push;
  result_t           push_data;
  result_t           out_data;
  logic              ram_wr_en;
  logic [COL_AW-1:0] ram_wr_addr;
  logic [PAIR_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [COL_AW-1:0] ram_rd_addr;
  logic [PAIR_W-1:0] ram_rd_data;

  pool22_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pool22_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (samples.valid),
    .in_sample   (samples.sample),
    .in_ready    (samples.ready),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  pool22_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (MAX_OUT_COLS),
    .AW    (COL_AW)
  ) u_colbuf (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  pool22_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (out_data)
  );

  assign results.pooled_value = out_data.value;
  assign results.map_done     = out_data.done;

endmodule

/* rtl/pool22_check.sv */
`timescale 1ns / 1ps
// port-level assertions for the pooling block, bound to the top level
// depends on pool22_pkg
module pool22_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           sample_ready,
  input logic                           result_valid,
  input logic                           result_ready,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [pool22_pkg::PADDR_W-1:0] paddr,
  input logic [pool22_pkg::PDATA_W-1:0] pwdata,
  input logic [pool22_pkg::PDATA_W-1:0] prdata,
  input logic                           pready
);
  import pool22_pkg::*;

  // a pending result transaction is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result valid dropped while stalled");

  // input is only held off when results are backed up
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !sample_ready |-> result_valid)
    else $error("input stalled with no pending result");

  // no result is left over from before reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // the mode register reads back what was written
  a_mode_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_POOL_MODE
     ##1 paddr[PADDR_W-1:2] == REG_POOL_MODE) |-> prdata[0] == $past(pwdata[0]))
    else $error("pool_mode readback mismatch");

endmodule

bind pool_2x2_average_max pool22_check u_check (
  .clk          (clk),
  .rst          (rst),
  .sample_ready (samples.ready),
  .result_valid (results.valid),
  .result_ready (results.ready),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata),
  .pready       (pready)
);
